// File: design/par_pkg.sv
package par_pkg;

  localparam int unsigned PIXELS_DEFAULT = 65536;
  localparam int unsigned FRAME_BITS_DEFAULT = 16;
  localparam int unsigned CNT_W = 24;
  localparam int unsigned ONE_Q12 = 4096;
  localparam int unsigned GAMMA_SCALE = 65025;
  localparam int unsigned DIV_STEPS = 31;

  typedef enum logic {
    OP_SAMPLE  = 1'b0,
    OP_RESTART = 1'b1
  } op_t;

  typedef struct packed {
    logic               op;
    logic [15:0]        pixel_index;
    logic signed [15:0] sample_red;
    logic signed [15:0] sample_green;
    logic signed [15:0] sample_blue;
    logic               last_of_frame;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_index;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
  } out_item_t;

  typedef struct packed {
    logic [15:0]        pixel_index;
    logic signed [15:0] sample_red;
    logic signed [15:0] sample_green;
    logic signed [15:0] sample_blue;
    logic               overwrite;
    logic [CNT_W-1:0]   divisor;
  } task_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic count_is_one;
    logic count_is_zero;
  } front_status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_ADD,
    BK_DIV,
    BK_MUL,
    BK_SQRT,
    BK_DONE
  } back_state_t;

endpackage

// File: design/par_front.sv
module par_front #(
  parameter int unsigned MAX_PIXELS = 65536,
  parameter int unsigned FRAME_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic                     cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  par_pkg::in_item_t        in_item,
  input  logic                     q_full,
  output logic                     q_push,
  output par_pkg::task_t           q_task,
  output par_pkg::front_status_t   status
);
  import par_pkg::*;

  localparam logic [FRAME_BITS-1:0] FC_MAX = {FRAME_BITS{1'b1}};
  localparam logic [FRAME_BITS-1:0] FC_ONE = FRAME_BITS'(1);

  logic                  acc_r, acc_nxt;
  logic [FRAME_BITS-1:0] fc_r, fc_nxt;
  logic                  accept;
  logic                  in_range;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign in_range = 32'(in_item.pixel_index) < 32'(MAX_PIXELS);

  always_comb begin
    acc_nxt = cfg_we ? cfg_wdata : acc_r;
    fc_nxt  = fc_r;
    q_push  = 1'b0;
    q_task.pixel_index  = in_item.pixel_index;
    q_task.sample_red   = in_item.sample_red;
    q_task.sample_green = in_item.sample_green;
    q_task.sample_blue  = in_item.sample_blue;
    q_task.overwrite    = !acc_r || (fc_r == FC_ONE);
    q_task.divisor      = (acc_r && fc_r != '0) ? CNT_W'(fc_r) : CNT_W'(1);
    if (accept) begin
      if (in_item.op == OP_RESTART) begin
        fc_nxt = FC_ONE;
      end else begin
        q_push = in_range;
        if (in_item.last_of_frame && acc_r && fc_r < FC_MAX) begin
          fc_nxt = fc_r + FC_ONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= 1'b1;
      fc_r  <= FC_ONE;
    end else begin
      acc_r <= acc_nxt;
      fc_r  <= fc_nxt;
    end
  end

  assign status.count_is_one  = (fc_r == FC_ONE);
  assign status.count_is_zero = (fc_r == '0);
endmodule

// File: design/par_queue.sv
module par_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  par_pkg::task_t         push_task,
  input  logic                   pop,
  output logic                   pop_valid,
  output par_pkg::task_t         pop_task,
  output par_pkg::queue_status_t status
);
  import par_pkg::*;

  task_t      store_r [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_pop;

  assign do_pop   = pop && cnt_r != 2'd0;
  assign pop_valid = cnt_r != 2'd0;
  assign pop_task  = store_r[rd_r];

  always_comb begin
    wr_nxt  = push ? !wr_r : wr_r;
    rd_nxt  = do_pop ? !rd_r : rd_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_r] <= push_task;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign status.full  = cnt_r == 2'd2;
  assign status.empty = cnt_r == 2'd0;
endmodule

// File: design/par_back.sv
module par_back #(
  parameter int unsigned MAX_PIXELS = 65536,
  parameter int unsigned FRAME_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  par_pkg::task_t      q_task,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output par_pkg::out_item_t  out_item
);
  import par_pkg::*;

  localparam int unsigned ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

  back_state_t state_r, state_nxt;
  task_t       task_r;
  logic [95:0] mem [MAX_PIXELS];
  logic [95:0] rd_r;
  logic [95:0] wdata;
  logic        mem_we;
  logic [ADDR_W-1:0] addr;
  logic [4:0]  step_r, step_nxt;

  logic [30:0]         num_r [3];
  logic [30:0]         num_nxt [3];
  logic [FRAME_BITS:0] rem_r [3];
  logic [FRAME_BITS:0] rem_nxt [3];
  logic [27:0]         v_r [3];
  logic [27:0]         v_nxt [3];
  logic [7:0]          res_r [3];
  logic [7:0]          res_nxt [3];

  logic signed [15:0]  smp [3];
  logic signed [31:0]  old [3];
  logic signed [32:0]  raw [3];
  logic signed [31:0]  sat [3];
  logic [FRAME_BITS:0] rem_sh [3];
  logic [FRAME_BITS:0] dvs;
  logic [12:0]         avg [3];
  logic [7:0]          cand [3];
  logic [13:0]         tval [3];
  logic [27:0]         tsq [3];

  assign addr = ADDR_W'(32'(task_r.pixel_index));
  assign dvs  = {1'b0, task_r.divisor[FRAME_BITS-1:0]};

  always_comb begin
    smp[0] = task_r.sample_red;
    smp[1] = task_r.sample_green;
    smp[2] = task_r.sample_blue;
    old[0] = rd_r[95:64];
    old[1] = rd_r[63:32];
    old[2] = rd_r[31:0];
    for (int l = 0; l < 3; l++) begin
      raw[l] = task_r.overwrite ? 33'(smp[l]) : (33'(old[l]) + 33'(smp[l]));
      if (raw[l][32] != raw[l][31]) begin
        sat[l] = raw[l][32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
        sat[l] = raw[l][31:0];
      end
      rem_sh[l] = {rem_r[l][FRAME_BITS-1:0], num_r[l][30]};
      avg[l]    = (num_r[l] > 31'(ONE_Q12)) ? 13'(ONE_Q12) : num_r[l][12:0];
      cand[l]   = res_r[l] | (8'd1 << step_r[2:0]);
      tval[l]   = {cand[l], 6'b0} - 14'd32;
      tsq[l]    = 28'(tval[l] * tval[l]);
    end
    wdata = {sat[0], sat[1], sat[2]};
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    for (int l = 0; l < 3; l++) begin
      num_nxt[l] = num_r[l];
      rem_nxt[l] = rem_r[l];
      v_nxt[l]   = v_r[l];
      res_nxt[l] = res_r[l];
    end
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = BK_READ;
        end
      end
      BK_READ: state_nxt = BK_ADD;
      BK_ADD: begin
        mem_we = 1'b1;
        for (int l = 0; l < 3; l++) begin
          num_nxt[l] = (sat[l] > 0) ? sat[l][30:0] : 31'd0;
          rem_nxt[l] = '0;
        end
        step_nxt  = 5'd0;
        state_nxt = BK_DIV;
      end
      BK_DIV: begin
        for (int l = 0; l < 3; l++) begin
          if (rem_sh[l] >= dvs) begin
            rem_nxt[l] = rem_sh[l] - dvs;
            num_nxt[l] = {num_r[l][29:0], 1'b1};
          end else begin
            rem_nxt[l] = rem_sh[l];
            num_nxt[l] = {num_r[l][29:0], 1'b0};
          end
        end
        step_nxt = step_r + 5'd1;
        if (step_r == 5'(DIV_STEPS - 1)) begin
          state_nxt = BK_MUL;
        end
      end
      BK_MUL: begin
        for (int l = 0; l < 3; l++) begin
          v_nxt[l]   = 28'(16'(GAMMA_SCALE) * avg[l]);
          res_nxt[l] = 8'd0;
        end
        step_nxt  = 5'd7;
        state_nxt = BK_SQRT;
      end
      BK_SQRT: begin
        for (int l = 0; l < 3; l++) begin
          if (tsq[l] <= v_r[l]) begin
            res_nxt[l] = cand[l];
          end
        end
        step_nxt = step_r - 5'd1;
        if (step_r == 5'd0) begin
          state_nxt = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!out_stall) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == BK_READ) begin
      rd_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      task_r <= q_task;
    end
    step_r <= step_nxt;
    for (int l = 0; l < 3; l++) begin
      num_r[l] <= num_nxt[l];
      rem_r[l] <= rem_nxt[l];
      v_r[l]   <= v_nxt[l];
      res_r[l] <= res_nxt[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign out_valid          = (state_r == BK_DONE);
  assign out_item.out_index = task_r.pixel_index;
  assign out_item.out_red   = res_r[0];
  assign out_item.out_green = res_r[1];
  assign out_item.out_blue  = res_r[2];
endmodule

// File: design/progressive_accumulation_resolve_core.sv
// Channel   Direction  Handshake         Payload
// in_       input      in_valid/in_stall  in_item_t: op, index, Q3.12 RGB, last mark
// out_      output     out_valid/out_stall out_item_t: index and three gamma bytes
// cfg_      input      cfg_we             cfg_wdata: accumulate enable
//
// Each pixel sample passes through the back end in order: a pop, the
// accumulator read, the add and write-back, the restoring divider (one lane
// per channel), one multiply and eight square-root steps, then the output
// stage, which holds while out_stall is high.
// Restart items and out-of-range samples are handled in the front.
// Reset is synchronous and active low; the frame count returns to one and
// accumulation is enabled. The accumulator memory is not cleared.
// A two-entry queue lets the front keep taking items while the back end is busy
// or the output is stalled.
module progressive_accumulation_resolve_core #(
  parameter int unsigned MAX_PIXELS = par_pkg::PIXELS_DEFAULT,
  parameter int unsigned FRAME_BITS = par_pkg::FRAME_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  par_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output par_pkg::out_item_t  out_item
);
  import par_pkg::*;

  // Front to queue: one task per accepted in-range sample, carrying the
  // overwrite decision and divisor taken at acceptance time.
  logic          q_push;
  task_t         push_task;
  logic          q_pop;
  logic          q_valid;
  task_t         pop_task;
  queue_status_t q_status;
  front_status_t f_status;

  par_front #(
    .MAX_PIXELS(MAX_PIXELS),
    .FRAME_BITS(FRAME_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_status.full),
    .q_push   (q_push),
    .q_task   (push_task),
    .status   (f_status)
  );

  par_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_task(push_task),
    .pop      (q_pop),
    .pop_valid(q_valid),
    .pop_task (pop_task),
    .status   (q_status)
  );

  // The back end performs the read-modify-write and the resolve for one item
  // at a time, so no read can overtake an earlier write to the same pixel.
  par_back #(
    .MAX_PIXELS(MAX_PIXELS),
    .FRAME_BITS(FRAME_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_task   (pop_task),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  a_queue_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_status.full && q_status.empty))
    else $error("queue reports full and empty at once");

  a_restart_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_item.op == OP_RESTART) |=> f_status.count_is_one)
    else $error("restart did not return the frame count to one");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    !f_status.count_is_zero)
    else $error("frame count reached zero");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_status.full)
    else $error("task pushed into a full queue");
endmodule

// File: bench/progressive_accumulation_resolve_core_tb.sv
module progressive_accumulation_resolve_core_tb;
  import par_pkg::*;

  // The back end handles one sample at a time, so a drain takes a while.
  localparam int SETTLE_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int REPORT_LIMIT = 10;
  localparam int FRAME_MAX = 65535;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;
  logic in_valid;
  logic in_stall;
  in_item_t in_item;
  logic out_valid;
  logic out_stall;
  out_item_t out_item;

  progressive_accumulation_resolve_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item)
  );

  // Shadow copy of the block's state. Accumulators are kept only for pixels
  // that have been written, which also tells the stimulus where adding is legal.
  int pixel_sum_r[int];
  int pixel_sum_g[int];
  int pixel_sum_b[int];
  int written_pixels[$];
  int frame_count;
  bit averaging_on;

  out_item_t pending_colours[$];

  int send_idle_pct;
  int recv_idle_pct;
  int recv_hold_left;
  int idle_cycles;
  int mismatches;
  int samples_sent;
  int restarts_sent;
  int colours_checked;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Saturating add into a signed 32-bit accumulator.
  function automatic int clamp_sum(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  // Average over the frame count, clamp to one, then take the gamma-2 byte:
  // the largest m with (64m - 32)^2 <= 65025 * avg, i.e. rounding to nearest.
  function automatic logic [7:0] gamma_byte_of(int acc, int divisor);
    longint avg;
    longint target;
    longint t;
    int m;
    if (acc <= 0) return 8'd0;
    avg = longint'(acc) / divisor;
    if (avg > 4096) avg = 4096;
    target = 65025 * avg;
    for (m = 255; m > 0; m--) begin
      t = 64 * m - 32;
      if (t * t <= target) return m[7:0];
    end
    return 8'd0;
  endfunction

  // Updates the shadow state for one accepted item and queues its colour.
  task automatic predict_item(in_item_t it);
    bit overwrite;
    int idx;
    int divisor;
    out_item_t colour;
    if (op_t'(it.op) == OP_RESTART) begin
      frame_count = 1;
      return;
    end
    idx = it.pixel_index;
    overwrite = !averaging_on || frame_count == 1;
    if (!pixel_sum_r.exists(idx)) begin
      written_pixels.push_back(idx);
      pixel_sum_r[idx] = 0;
      pixel_sum_g[idx] = 0;
      pixel_sum_b[idx] = 0;
    end
    if (overwrite) begin
      pixel_sum_r[idx] = it.sample_red;
      pixel_sum_g[idx] = it.sample_green;
      pixel_sum_b[idx] = it.sample_blue;
    end else begin
      pixel_sum_r[idx] = clamp_sum(longint'(pixel_sum_r[idx]) + it.sample_red);
      pixel_sum_g[idx] = clamp_sum(longint'(pixel_sum_g[idx]) + it.sample_green);
      pixel_sum_b[idx] = clamp_sum(longint'(pixel_sum_b[idx]) + it.sample_blue);
    end
    divisor = (averaging_on && frame_count != 0) ? frame_count : 1;
    colour.out_index = it.pixel_index;
    colour.out_red = gamma_byte_of(pixel_sum_r[idx], divisor);
    colour.out_green = gamma_byte_of(pixel_sum_g[idx], divisor);
    colour.out_blue = gamma_byte_of(pixel_sum_b[idx], divisor);
    pending_colours.push_back(colour);
    if (it.last_of_frame && averaging_on && frame_count < FRAME_MAX) begin
      frame_count++;
    end
  endtask

  // Offers one item after an optional random gap and returns at the edge that
  // accepts it; valid is left high so a following item can go straight on.
  task automatic offer_item(in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_item = it;
    do begin
      @(posedge clk);
    end while (in_stall);
    predict_item(it);
  endtask

  // A sample that would add into a never-written accumulator is moved onto a
  // pixel that already holds a value.
  task automatic send_sample(int idx, logic signed [15:0] r, logic signed [15:0] g,
                             logic signed [15:0] b, bit last);
    in_item_t it;
    if (averaging_on && frame_count != 1 && !pixel_sum_r.exists(idx)) begin
      idx = written_pixels[$urandom_range(0, written_pixels.size() - 1)];
    end
    it.op = OP_SAMPLE;
    it.pixel_index = idx[15:0];
    it.sample_red = r;
    it.sample_green = g;
    it.sample_blue = b;
    it.last_of_frame = last;
    offer_item(it);
    samples_sent++;
  endtask

  // Restart ignores every other field, so they carry random noise.
  task automatic send_restart();
    in_item_t it;
    it = in_item_t'($bits(in_item_t)'({$urandom, $urandom, $urandom}));
    it.op = OP_RESTART;
    offer_item(it);
    restarts_sent++;
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_colours.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // The register is only written with the block drained and idle.
  task automatic set_averaging(bit enable);
    wait_for_drain();
    cfg_we = 1'b1;
    cfg_wdata = enable;
    @(negedge clk);
    cfg_we = 1'b0;
    averaging_on = enable;
  endtask

  // Mostly values in the visible range, with the odd full-scale or negative one.
  function automatic logic signed [15:0] random_channel();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
      2: return -$signed({1'b0, 15'($urandom_range(0, 4096))});
      default: return 16'($urandom_range(0, 4200));
    endcase
  endfunction

  task automatic test_directed();
    set_averaging(1'b1);
    // First frame overwrites, including both channel extremes and exactly one.
    send_sample(0, 16'sh7fff, 16'sh8000, 16'sd4096, 1'b0);
    send_sample(65535, 16'sd0, 16'sd1, 16'sd4095, 1'b0);
    send_sample(1, 16'sd4097, -16'sd1, 16'sd2048, 1'b1);
    // Second frame adds and divides by two; a third-frame sample at pixel 0 divides by three.
    send_sample(0, 16'sh7fff, 16'sh7fff, 16'sd4096, 1'b0);
    send_sample(65535, 16'sd8192, 16'sd3, 16'sh8000, 1'b0);
    send_sample(1, 16'sd4095, 16'sd1, 16'sd2048, 1'b1);
    send_sample(0, 16'sh8000, 16'sh8000, 16'sd1, 1'b1);
    // Restart brings the count back to one, so the next sample overwrites.
    send_restart();
    send_sample(0, 16'sd1, 16'sd4096, 16'sd100, 1'b0);
    send_sample(65535, 16'sd1024, 16'sd9, 16'sd3000, 1'b1);
    send_sample(65535, 16'sd1024, 16'sd9, 16'sd3000, 1'b1);
    // With averaging off the latest sample shows directly and the count holds.
    set_averaging(1'b0);
    send_sample(1, 16'sd1000, 16'sd2000, 16'sd4000, 1'b1);
    send_sample(1, 16'sd16, 16'sd0, 16'sh7fff, 1'b1);
    send_sample(21845, 16'sh5555, 16'shaaaa, 16'sd1, 1'b0);
    send_restart();
    set_averaging(1'b1);
    send_sample(1, 16'sd50, 16'sd60, 16'sd70, 1'b1);
    send_sample(1, 16'sd50, 16'sd60, 16'sd70, 1'b0);
    wait_for_drain();
  endtask

  // Whole frames over a small random set of pixels, with the odd restart or
  // stray sample thrown in.
  task automatic test_random_frames(int target);
    int pool[$];
    int n;
    int i;
    int sent;
    sent = 0;
    while (sent < target) begin
      if (pool.size() == 0 || $urandom_range(0, 9) == 0) begin
        pool.delete();
        n = $urandom_range(1, 8);
        for (i = 0; i < n; i++) pool.push_back($urandom_range(0, 65535));
      end
      case ($urandom_range(0, 19))
        0: begin
          send_restart();
          sent++;
        end
        1: begin
          send_sample($urandom_range(0, 65535), random_channel(), random_channel(),
                      random_channel(), 1'($urandom_range(0, 1)));
          sent++;
        end
        default: begin
          foreach (pool[k]) begin
            send_sample(pool[k], random_channel(), random_channel(), random_channel(),
                        k == pool.size() - 1);
          end
          sent += pool.size();
        end
      endcase
    end
    wait_for_drain();
  endtask

  // The receiver holds off while the sender keeps going, so the queue fills
  // and the input stalls; then the sender waits for everything to come out.
  task automatic test_output_backpressure();
    int i;
    send_idle_pct = 0;
    recv_hold_left = 600;
    for (i = 0; i < 12; i++) begin
      send_sample($urandom_range(0, 65535), random_channel(), random_channel(),
                  random_channel(), i == 11);
    end
    wait_for_drain();
  endtask

  // The receiver either works off a long hold-off or stalls at random.
  always @(negedge clk) begin
    if (recv_hold_left > 0) begin
      recv_hold_left <= recv_hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Each accepted colour is checked against the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      colours_checked++;
      if (pending_colours.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) $display("unexpected colour %p", out_item);
      end else begin
        want = pending_colours.pop_front();
        if (out_item.out_index !== want.out_index || out_item.out_red !== want.out_red ||
            out_item.out_green !== want.out_green || out_item.out_blue !== want.out_blue) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("colour differs: expected %p, got %p", want, out_item);
          end
        end
      end
    end
  end

  // Ends the run if neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d colours outstanding", pending_colours.size());
      $display("progressive_accumulation_resolve_core: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    recv_hold_left = 0;
    idle_cycles = 0;
    mismatches = 0;
    samples_sent = 0;
    restarts_sent = 0;
    colours_checked = 0;
    frame_count = 1;
    averaging_on = 1'b1;
    send_idle_pct = 38;
    recv_idle_pct = 75;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_output_backpressure();
    send_idle_pct = 38;
    recv_idle_pct = 75;
    test_random_frames(420);
    set_averaging(1'b0);
    send_idle_pct = 75;
    recv_idle_pct = 38;
    test_random_frames(380);
    set_averaging(1'b1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_frames(700);

    wait_for_drain();
    mismatches += pending_colours.size();
    $display("run covered %0d samples and %0d restarts over %0d pixels, %0d colours checked",
             samples_sent, restarts_sent, written_pixels.size(), colours_checked);
    $display("with averaging on and off, random idling on both sides and a long output hold");
    if (mismatches == 0) begin
      $display("progressive_accumulation_resolve_core: match");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("progressive_accumulation_resolve_core: mismatch");
    end
    $finish;
  end

endmodule
